// ===== rtl/indexed_pixel_palette_expander_macros.svh =====
// Assertion helpers for the top-level RTL file.
`ifndef INDEXED_PIXEL_PALETTE_EXPANDER_MACROS_SVH
`define INDEXED_PIXEL_PALETTE_EXPANDER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IPX_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define IPX_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/ipx_pkg.sv =====
package ipx_pkg;

   // Palette geometry
   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   // Item commands
   typedef enum logic [0:0] {
      CMD_PAL_WRITE = 1'b0,
      CMD_EXPAND    = 1'b1
   } cmd_type;

   // Bits-per-pixel setting
   typedef enum logic [1:0] {
      DEPTH_1 = 2'd0,
      DEPTH_2 = 2'd1,
      DEPTH_4 = 2'd2,
      DEPTH_8 = 2'd3
   } depth_type;

   localparam depth_type DEPTH_RESET = DEPTH_8;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] palette_index;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] pixel_byte;
   } req_type;

   typedef struct packed {
      logic [15:0] pixel;
      logic        last;
   } rsp_type;

   // One stored palette entry: five bits per component
   typedef struct packed {
      logic [4:0] r5;
      logic [4:0] g5;
      logic [4:0] b5;
   } pal_entry_type;

   typedef struct packed {
      logic              en;
      logic [PAL_AW-1:0] addr;
      pal_entry_type     data;
   } pal_wr_type;

   typedef struct packed {
      logic              en;
      logic [PAL_AW-1:0] addr;
   } pal_rd_type;

   // Position of the final pixel within one byte
   function automatic logic [2:0] last_slot(depth_type d);
      logic [2:0] r;
      unique case (d)
         DEPTH_1: r = 3'd7;
         DEPTH_2: r = 3'd3;
         DEPTH_4: r = 3'd1;
         DEPTH_8: r = 3'd0;
         default: r = 3'd0;
      endcase
      return r;
   endfunction

   // Index for slot k: LSB first at one bit, MSB field first otherwise
   function automatic logic [7:0] unpack_index(logic [7:0] b, depth_type d,
                                                logic [2:0] k);
      logic [7:0] sh;
      logic [7:0] r;
      sh = 8'h00;
      unique case (d)
         DEPTH_1: r = {7'b0, b[k]};
         DEPTH_2: begin
            sh = b << {k[1:0], 1'b0};
            r  = {6'b0, sh[7:6]};
         end
         DEPTH_4: begin
            sh = b << {k[0], 2'b00};
            r  = {4'b0, sh[7:4]};
         end
         DEPTH_8: r = b;
         default: r = b;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/ipx_palette.sv =====
module ipx_palette (
   input  logic                   clock,
   input  ipx_pkg::pal_wr_type    wr,
   input  ipx_pkg::pal_rd_type    rd,
   output ipx_pkg::pal_entry_type rd_data
);
   import ipx_pkg::*;

   pal_entry_type palette_ff [PALETTE_ENTRIES];
   pal_entry_type rd_data_ff;

   // Single write port, single registered read port; read data holds when idle
   always_ff @(posedge clock) begin
      if (wr.en) begin
         palette_ff[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= palette_ff[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/indexed_pixel_palette_expander.sv =====
// Palette expander: a palette-write transaction stores the top five bits of red,
// green and blue into one of 256 entries and gives no result. A pixel-byte
// transaction is split by the depth setting (1, 2, 4 or 8 bits per pixel) and
// yields 8, 4, 2 or 1 pixels while it waits in the item register, one per cycle
// unless rsp_stall holds the output; the single read port of the palette memory
// sets that one-pixel-per-clock pace. The first pixel reaches rsp via the item
// register and then the palette read register. The next transaction is taken in
// the cycle its predecessor finishes. The output register holds while rsp_stall
// is high. Pixels are {red5, green5, 1'b0, blue5}; last marks the final pixel of
// a byte. Only read palette entries that were written first. Change depth only
// while the block is idle; csr_ready is always high.
`include "indexed_pixel_palette_expander_macros.svh"

module indexed_pixel_palette_expander (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  ipx_pkg::req_type   req_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output ipx_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  ipx_pkg::depth_type csr_data
);
   import ipx_pkg::*;

   depth_type     depth_ff;
   logic          item_valid_ff, item_valid_in;
   req_type       item_ff, item_in;
   logic [2:0]    slot_ff, slot_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          last_ff, last_in;
   logic          oor_ff, oor_in;

   logic          out_free;
   logic          rd_en;
   logic          wr_en;
   logic          slot_last;
   logic          done;
   logic          accept;
   logic [7:0]    pix_idx;
   pal_wr_type    pal_wr;
   pal_rd_type    pal_rd;
   pal_entry_type pal_q;

   // Depth register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= DEPTH_RESET;
      end else if (csr_valid && csr_ready) begin
         depth_ff <= csr_data;
      end
   end

   // Item control: writes finish at once, bytes step one slot per free output cycle
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wr_en     = item_valid_ff && (item_ff.command == CMD_PAL_WRITE);
   assign rd_en     = item_valid_ff && (item_ff.command == CMD_EXPAND) && out_free;
   assign slot_last = (slot_ff == last_slot(depth_ff));
   assign done      = wr_en || (rd_en && slot_last);
   assign req_stall = item_valid_ff && !done;
   assign accept    = req_valid && !req_stall;
   assign pix_idx   = unpack_index(item_ff.pixel_byte, depth_ff, slot_ff);

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      slot_in       = slot_ff;
      if (done) begin
         item_valid_in = 1'b0;
      end
      if (rd_en) begin
         slot_in = slot_ff + 3'd1;
      end
      if (accept) begin
         item_in       = req_data;
         item_valid_in = 1'b1;
         slot_in       = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         slot_ff       <= 3'd0;
      end else begin
         item_valid_ff <= item_valid_in;
         slot_ff       <= slot_in;
      end
      item_ff <= item_in;
   end

   // Palette access
   always_comb begin
      pal_wr.en      = wr_en &&
                       ({1'b0, item_ff.palette_index} < 9'(PALETTE_ENTRIES));
      pal_wr.addr    = item_ff.palette_index[PAL_AW-1:0];
      pal_wr.data.r5 = item_ff.red[7:3];
      pal_wr.data.g5 = item_ff.green[7:3];
      pal_wr.data.b5 = item_ff.blue[7:3];
      pal_rd.en      = rd_en;
      pal_rd.addr    = pix_idx[PAL_AW-1:0];
   end

   ipx_palette u_palette (
      .clock   (clock),
      .wr      (pal_wr),
      .rd      (pal_rd),
      .rd_data (pal_q)
   );

   // Result register: flags travel alongside the registered palette read
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      oor_in       = oor_ff;
      if (out_free) begin
         rsp_valid_in = rd_en;
      end
      if (rd_en) begin
         last_in = slot_last;
         oor_in  = !({1'b0, pix_idx} < 9'(PALETTE_ENTRIES));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff <= last_in;
      oor_ff  <= oor_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data.last  = last_ff;
   assign rsp_data.pixel = oor_ff ? 16'h0000 : {pal_q.r5, pal_q.g5, 1'b0, pal_q.b5};

   // Checks
   `IPX_ASSERT_IMPLY(a_rw_exclusive, clock, reset, wr_en, !rd_en, "palette read and write together")
   `IPX_ASSERT_NEXT(a_read_gives_rsp, clock, reset, rd_en, rsp_valid, "palette read lost its result")
   `IPX_ASSERT_NEXT(a_last_mark, clock, reset, rd_en && slot_last, rsp_data.last, "last mark missing")
   `IPX_ASSERT_IMPLY(a_slot_range, clock, reset, item_valid_ff && (item_ff.command == CMD_EXPAND), slot_ff <= last_slot(depth_ff), "slot beyond byte")
   `IPX_ASSERT_NEXT(a_item_holds, clock, reset, item_valid_ff && !done, item_valid_ff && $stable(item_ff), "pending item changed")

endmodule

// ===== test/ipx_checker.sv =====
`timescale 1ns / 1ps

// Watches the request, response and csr channels, keeps a shadow of the palette
// and the depth setting, and checks every response transaction against the
// pixels predicted for the accepted pixel bytes.
module ipx_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  ipx_pkg::req_type   req_data,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  ipx_pkg::rsp_type   rsp_data,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  ipx_pkg::depth_type csr_data,
   output int                 n_fail,
   output int                 n_pending,
   output int                 n_pixels
);
   import ipx_pkg::*;

   pal_entry_type color_table [PALETTE_ENTRIES];
   depth_type     bpp_mode = DEPTH_RESET;
   rsp_type       pixel_queue [$];
   int            fail_cnt = 0;
   int            pixel_cnt = 0;
   int            queue_len = 0;

   assign n_fail    = fail_cnt;
   assign n_pending = queue_len;
   assign n_pixels  = pixel_cnt;

   // Palette lookup; indices past the table give a black pixel
   function automatic logic [15:0] color_of(logic [7:0] idx);
      pal_entry_type e;
      if (idx >= PALETTE_ENTRIES)
         return 16'h0000;
      e = color_table[idx];
      return {e.r5, e.g5, 1'b0, e.b5};
   endfunction

   // Split one byte at the given depth and queue the pixels it yields
   task automatic expand_pixels(input logic [7:0] pbyte, input depth_type d);
      int         bits;
      int         count;
      int         sh;
      logic [7:0] mask;
      logic [7:0] idx;
      rsp_type    p;
      bits  = 1 << d;
      count = 8 / bits;
      mask  = 8'((1 << bits) - 1);
      for (int k = 0; k < count; k++) begin
         // one bit per pixel runs LSB first, wider fields MSB first
         sh      = (bits == 1) ? k : 8 - bits * (k + 1);
         idx     = (pbyte >> sh) & mask;
         p.pixel = color_of(idx);
         p.last  = (k == count - 1);
         pixel_queue.push_back(p);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         bpp_mode = DEPTH_RESET;
         pixel_queue.delete();
         foreach (color_table[i])
            color_table[i] = '0;
      end else begin
         if (csr_valid && csr_ready)
            bpp_mode = csr_data;

         // compare a response transaction with the oldest prediction
         if (rsp_valid && !rsp_stall) begin
            if (pixel_queue.size() == 0) begin
               fail_cnt++;
               $display("%0t ipx_checker: unexpected pixel, expected none, got %h last %b",
                        $time, rsp_data.pixel, rsp_data.last);
            end else begin
               want = pixel_queue.pop_front();
               pixel_cnt++;
               if (rsp_data.pixel !== want.pixel) begin
                  fail_cnt++;
                  $display("%0t ipx_checker: pixel mismatch, expected %h, got %h",
                           $time, want.pixel, rsp_data.pixel);
               end
               if (rsp_data.last !== want.last) begin
                  fail_cnt++;
                  $display("%0t ipx_checker: last mismatch, expected %b, got %b",
                           $time, want.last, rsp_data.last);
               end
            end
         end

         // request transaction: palette update or byte expansion
         if (req_valid && !req_stall) begin
            if (req_data.command == CMD_PAL_WRITE) begin
               if (req_data.palette_index < PALETTE_ENTRIES)
                  color_table[req_data.palette_index] = '{r5: req_data.red[7:3],
                                                          g5: req_data.green[7:3],
                                                          b5: req_data.blue[7:3]};
            end else begin
               expand_pixels(req_data.pixel_byte, bpp_mode);
            end
         end
      end
      queue_len = pixel_queue.size();
   end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import ipx_pkg::*;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   req_type   req_data = '0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   rsp_type   rsp_data;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   depth_type csr_data = DEPTH_8;

   int        n_fail;
   int        n_pending;
   int        n_pixels;

   bit        quiet = 1'b0;     // no random idling on either side
   bit        hold_go = 1'b0;   // asks the response side for a long hold-off
   bit        written [PALETTE_ENTRIES];
   int        items_sent = 0;
   depth_type cur_depth = DEPTH_RESET;
   depth_type phase_depth [6] = '{DEPTH_8, DEPTH_1, DEPTH_4, DEPTH_2, DEPTH_8, DEPTH_1};

   always #6 clock = ~clock;

   indexed_pixel_palette_expander u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   ipx_checker u_checker (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .n_fail    (n_fail),
      .n_pending (n_pending),
      .n_pixels  (n_pixels)
   );

   // Palette write transaction; pixel_byte is a don't-care
   function automatic req_type pal_item(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                        logic [7:0] b);
      req_type t;
      t.command       = CMD_PAL_WRITE;
      t.palette_index = idx;
      t.red           = r;
      t.green         = g;
      t.blue          = b;
      t.pixel_byte    = 8'($urandom_range(0, 255));
      return t;
   endfunction

   // Pixel byte transaction; color fields are don't-cares
   function automatic req_type pix_item(logic [7:0] pbyte);
      req_type t;
      t.command       = CMD_EXPAND;
      t.palette_index = 8'($urandom_range(0, 255));
      t.red           = 8'($urandom_range(0, 255));
      t.green         = 8'($urandom_range(0, 255));
      t.blue          = 8'($urandom_range(0, 255));
      t.pixel_byte    = pbyte;
      return t;
   endfunction

   // Random byte whose indices all point at written entries
   function automatic logic [7:0] rand_byte();
      logic [7:0] b;
      int         start;
      b = 8'($urandom_range(0, 255));
      if (cur_depth == DEPTH_8 && !written[b]) begin
         start = $urandom_range(0, 255);
         for (int j = 0; j < PALETTE_ENTRIES; j++) begin
            if (written[(start + j) % PALETTE_ENTRIES]) begin
               b = 8'((start + j) % PALETTE_ENTRIES);
               break;
            end
         end
      end
      return b;
   endfunction

   // Offer one transaction at the falling edge and hold it until accepted
   task automatic push_item(input req_type item);
      while (!quiet && $urandom_range(0, 99) < 13) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (item.command == CMD_PAL_WRITE)
         written[item.palette_index] = 1'b1;
   endtask

   // Depth change only once the block has drained
   task automatic set_depth(input depth_type d);
      req_valid <= 1'b0;
      while (n_pending != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      cur_depth = d;
   endtask

   // Random mix of palette updates and pixel bytes
   task automatic run_phase(input int n);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 99) < 30)
            push_item(pal_item(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                               8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))));
         else
            push_item(pix_item(rand_byte()));
      end
   endtask

   // Response side: random stalls, plus one long hold-off on request
   initial begin : rsp_side
      int hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_go) begin
            hold_left = 100;
            hold_go   = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(0, 99) < 13);
         end
      end
   end

   // Stimulus and verdict
   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes of the palette, entries for the narrow depths
      push_item(pal_item(8'h00, 8'h00, 8'h00, 8'h00));
      push_item(pal_item(8'hFF, 8'hFF, 8'hFF, 8'hFF));
      for (int i = 1; i < 16; i++)
         push_item(pal_item(8'(i), 8'(i * 16 + 7), 8'(255 - i * 16), 8'(i * 17)));
      push_item(pix_item(8'h00));
      push_item(pix_item(8'hFF));
      push_item(pix_item(8'h0F));
      set_depth(DEPTH_1);
      push_item(pix_item(8'hA5));
      push_item(pix_item(8'h01));
      set_depth(DEPTH_2);
      push_item(pix_item(8'hE4));
      set_depth(DEPTH_4);
      push_item(pix_item(8'h5A));

      // random phases over every depth
      for (int ph = 0; ph < 6; ph++) begin
         set_depth(phase_depth[ph]);
         quiet = (ph == 0);
         if (ph == 1)
            hold_go = 1'b1;
         run_phase(21);
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      while (n_pending != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);

      $display("tb_top: %0d transactions sent, %0d pixels checked at depths 1, 2, 4 and 8,",
               items_sent, n_pixels);
      $display("tb_top: with random idling, one idle-free phase and a 100-cycle output hold-off");
      if (n_fail == 0)
         $display("tb_top: PASS");
      else
         $display("tb_top: FAIL");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("tb_top: FAIL");
      $finish;
   end

endmodule
